// ----- rtl/core/iptt_pkg.sv -----
// iptt_pkg: shared types for the indexed priority task table
// mode codes and the command/status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iptt_pkg;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_EDIT   = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_EXEC   = 2'd3
    } mode_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_cmd;    // capture the accepted request
        logic cnt_clear;    // return slot counter to zero
        logic cnt_inc;      // advance slot counter
        logic init_wr;      // clearing pass: zero the slot at the counter
        logic rd_cmd;       // read the slot named by the request
        logic scan_rd;      // read the slot at the counter for the max search
        logic cmd_wr;       // write back add, edit or remove
        logic exec_wr;      // clear the winning slot of an exec_top
        logic load_result;  // load the result register
        logic exec_result;  // result comes from the max search
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_last;     // counter is at the last slot
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/iptt_datapath.sv -----
// iptt_datapath: task table memory, slot counter, max search and result register
// depends on iptt_pkg for the command and status structs and mode codes
`timescale 1ns / 1ps
`default_nettype none

module iptt_datapath #(
    parameter int TASK_SLOTS    = 256,
    parameter int PRIORITY_BITS = 32,
    parameter int USER_BITS     = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire iptt_pkg::cmd_t    cmd,
    output iptt_pkg::status_t      status,
    input  wire logic [1:0]        s_mode,
    input  wire logic [7:0]        s_task_id,
    input  wire logic [15:0]       s_user_id,
    input  wire logic [31:0]       s_priority_req,
    output logic                   m_found,
    output logic [15:0]            m_user_id_out
);

    localparam int IDX_W = $clog2(TASK_SLOTS);

    typedef struct packed {
        logic                     valid;
        logic [PRIORITY_BITS-1:0] prio;
        logic [USER_BITS-1:0]     user;
    } entry_t;

    entry_t mem [TASK_SLOTS];
    entry_t rd_data_reg;

    // input shaping: index, range check, cut priority and user to table widths
    logic [IDX_W+7:0]          tid_ext;
    logic [PRIORITY_BITS+31:0] prio_ext;
    logic [USER_BITS+15:0]     user_ext;
    logic                      in_range;

    assign tid_ext  = {{IDX_W{1'b0}}, s_task_id};
    assign prio_ext = {{PRIORITY_BITS{1'b0}}, s_priority_req};
    assign user_ext = {{USER_BITS{1'b0}}, s_user_id};
    assign in_range = ({9'd0, s_task_id} < 17'(TASK_SLOTS));

    // latched request
    iptt_pkg::mode_t          mode_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [USER_BITS-1:0]     user_reg;
    logic                     in_range_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_cmd) begin
            mode_reg     <= iptt_pkg::mode_t'(s_mode);
            idx_reg      <= tid_ext[IDX_W-1:0];
            prio_reg     <= prio_ext[PRIORITY_BITS-1:0];
            user_reg     <= user_ext[USER_BITS-1:0];
            in_range_reg <= in_range;
        end
    end

    // slot counter for clearing pass and scan
    logic [IDX_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clear) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign status.cnt_last = (cnt_reg == IDX_W'(TASK_SLOTS - 1));

    // best-so-far of the max search
    logic                     cmp_pending_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     best_any_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [PRIORITY_BITS-1:0] best_prio_reg;
    logic [USER_BITS-1:0]     best_user_reg;
    logic                     take_best;

    // ascending scan, >= hands ties to the higher id
    assign take_best = cmp_pending_reg && rd_data_reg.valid &&
                       (!best_any_reg || (rd_data_reg.prio >= best_prio_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_pending_reg <= 1'b0;
            best_any_reg    <= 1'b0;
        end else begin
            cmp_pending_reg <= cmd.scan_rd;
            if (cmd.latch_cmd) begin
                best_any_reg <= 1'b0;
            end else if (take_best) begin
                best_any_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            cmp_idx_reg <= cnt_reg;
        end
        if (take_best) begin
            best_idx_reg  <= cmp_idx_reg;
            best_prio_reg <= rd_data_reg.prio;
            best_user_reg <= rd_data_reg.user;
        end
    end

    // memory port selection
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        if (cmd.init_wr) begin
            wr_en = 1'b1;
        end else if (cmd.cmd_wr) begin
            wr_en   = in_range_reg;
            wr_addr = idx_reg;
            case (mode_reg)
                iptt_pkg::MODE_ADD: begin
                    wr_data.valid = 1'b1;
                    wr_data.prio  = prio_reg;
                    wr_data.user  = user_reg;
                end
                iptt_pkg::MODE_EDIT: begin
                    // absent entry comes back with user zero
                    wr_data.valid = 1'b1;
                    wr_data.prio  = prio_reg;
                    wr_data.user  = rd_data_reg.valid ? rd_data_reg.user : '0;
                end
                default: begin
                    wr_data = '0;
                end
            endcase
        end else if (cmd.exec_wr) begin
            wr_en   = best_any_reg;
            wr_addr = best_idx_reg;
        end
    end

    assign rd_en   = cmd.rd_cmd || cmd.scan_rd;
    assign rd_addr = cmd.rd_cmd ? idx_reg : cnt_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result register
    logic [USER_BITS+15:0] best_user_ext;
    logic                  found_reg;
    logic [15:0]           user_out_reg;

    assign best_user_ext = {16'd0, best_user_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            if (cmd.exec_result && best_any_reg) begin
                found_reg    <= 1'b1;
                user_out_reg <= best_user_ext[15:0];
            end else begin
                found_reg    <= 1'b0;
                user_out_reg <= '0;
            end
        end
    end

    assign m_found       = found_reg;
    assign m_user_id_out = user_out_reg;

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.init_wr, cmd.cmd_wr, cmd.exec_wr}))
        else $error("more than one table write source active");

    a_cmp_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_rd |=> cmp_pending_reg)
        else $error("scan read not followed by compare");

    a_no_read_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec_wr |-> !rd_en)
        else $error("read issued while clearing the winning slot");

endmodule

`default_nettype wire

// ----- rtl/core/iptt_ctrl.sv -----
// iptt_ctrl: sequencer for clearing pass, request handling, scan and result handshake
// depends on iptt_pkg for the command and status structs and mode codes
`timescale 1ns / 1ps
`default_nettype none

module iptt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_mode,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output iptt_pkg::cmd_t         cmd,
    input  wire iptt_pkg::status_t status
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                if (status.cnt_last) begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.latch_cmd = 1'b1;
                    case (iptt_pkg::mode_t'(s_mode))
                        iptt_pkg::MODE_EDIT: state_next = ST_READ;
                        iptt_pkg::MODE_EXEC: state_next = ST_SCAN;
                        default:             state_next = ST_WRITE;
                    endcase
                end
            end
            ST_READ: begin
                cmd.rd_cmd = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.cmd_wr      = 1'b1;
                cmd.load_result = 1'b1;
                m_valid_next    = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (status.cnt_last) begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_DRAIN;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_DRAIN: begin
                // last compare lands at the end of this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.exec_wr     = 1'b1;
                cmd.load_result = 1'b1;
                cmd.exec_result = 1'b1;
                m_valid_next    = 1'b1;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> !m_valid_reg)
        else $error("result loaded over an untaken result");

    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT) |-> !s_ready)
        else $error("request accepted during clearing pass");

    a_exec_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_mode == iptt_pkg::MODE_EXEC)) |=> (state_reg == ST_SCAN))
        else $error("exec_top request did not start a scan");

endmodule

`default_nettype wire

// ----- rtl/core/indexed_priority_task_table_core.sv -----
// indexed_priority_task_table_core: top level of the indexed priority task table
// a table of TASK_SLOTS entries (valid, priority, user) kept in one memory.
// s_ channel carries a request: mode, task_id, user_id, priority_req.
// m_ channel carries one result per request: found, user_id_out.
// add and remove write the slot and load the result; edit does so too
// after a read of the stored entry (read, then write back).
// exec_top scans the table one slot per cycle through the memory read port;
// the winner is cleared in the same cycle as the result is loaded.
// one request is in work at a time; the next request is taken once the
// previous one is finished and its result is free or taken in that cycle.
// reset: aresetn synchronous, active low; afterwards a clearing pass zeroes
// the table slot by slot with s_ready low.
// when the receiver stalls the result is held in the output register and
// no further request is accepted until it is taken.
// depends on iptt_pkg, iptt_ctrl and iptt_datapath
`timescale 1ns / 1ps
`default_nettype none

module indexed_priority_task_table_core #(
    parameter int TASK_SLOTS    = 256,
    parameter int PRIORITY_BITS = 32,
    parameter int USER_BITS     = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_task_id,
    input  wire logic [15:0] s_user_id,
    input  wire logic [31:0] s_priority_req,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [15:0]      m_user_id_out
);

    iptt_pkg::cmd_t    cmd;
    iptt_pkg::status_t status;

    iptt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    iptt_datapath #(
        .TASK_SLOTS    (TASK_SLOTS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .USER_BITS     (USER_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_mode         (s_mode),
        .s_task_id      (s_task_id),
        .s_user_id      (s_user_id),
        .s_priority_req (s_priority_req),
        .m_found        (m_found),
        .m_user_id_out  (m_user_id_out)
    );

endmodule

`default_nettype wire
